/* rtl/lkv_pkg.sv */
// lkv_pkg: shared constants, payload types and match record for the LRU
// key/value cache. No dependencies; imported by every module under rtl/.
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

   typedef logic [SLOT_W-1:0]        slot_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic signed [KEY_W-1:0]  key_type;
   typedef logic signed [VAL_W-1:0]  value_type;

   typedef struct packed {
      logic      op;
      key_type   lookup_key;
      value_type write_value;
   } req_type;

   typedef struct packed {
      logic      hit;
      value_type read_value;
      logic      evicted;
      key_type   evicted_key;
   } rsp_type;

   // Outcome of the associative search over the slots.
   typedef struct packed {
      logic               hit;
      logic [ENTRIES-1:0] hit_oh;
      slot_type           hit_slot;
      logic               has_free;
      slot_type           free_slot;
   } match_type;

endpackage

/* rtl/lkv_match.sv */
// lkv_match: parallel key compare over all slots plus first-free-slot search.
// Depends on lkv_pkg.
module lkv_match
   import lkv_pkg::*;
(
   input  key_type            lookup_key,
   input  logic [ENTRIES-1:0] entry_valid,
   input  key_type            entry_key [ENTRIES],
   output match_type          match
);

   always_comb begin
      match = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         match.hit_oh[i] = entry_valid[i] && (entry_key[i] == lookup_key);
         if (match.hit_oh[i]) begin
            match.hit_slot = SLOT_W'(i);
         end
         // descending scan: lowest free slot wins
         if (!entry_valid[i]) begin
            match.free_slot = SLOT_W'(i);
         end
      end
      match.hit      = |match.hit_oh;
      match.has_free = ~&entry_valid;
   end

endmodule

/* rtl/lkv_store.sv */
// lkv_store: slot registers (valid, key, value, recency rank) and the
// get/put update with LRU victim choice. Depends on lkv_pkg, lkv_match.
module lkv_store
   import lkv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  req_type          item,
   input  logic [CAP_W-1:0] capacity,
   output rsp_type          result
);

   logic [ENTRIES-1:0] valid_ff, valid_in;
   key_type            key_ff   [ENTRIES];
   key_type            key_in   [ENTRIES];
   value_type          value_ff [ENTRIES];
   value_type          value_in [ENTRIES];
   slot_type           age_ff   [ENTRIES];
   slot_type           age_in   [ENTRIES];
   count_type          count_ff, count_in;

   match_type          match;
   logic [CMP_W-1:0]   cap_eff;
   logic [CMP_W-1:0]   count_wide;
   logic               is_put;
   slot_type           hit_age;
   value_type          hit_value;
   slot_type           oldest_age;
   slot_type           victim_age;
   logic [ENTRIES-1:0] victim_oh;
   slot_type           victim_slot;
   key_type            victim_key;
   logic               put_hit_evict;
   logic               put_miss_evict;
   slot_type           target;

   lkv_match u_match (
      .lookup_key  (item.lookup_key),
      .entry_valid (valid_ff),
      .entry_key   (key_ff),
      .match       (match)
   );

   // capacity 0 behaves as 1, anything above the slot count as the slot count
   always_comb begin
      cap_eff = CMP_W'(capacity);
      if (capacity == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end
   end

   assign count_wide = CMP_W'(count_ff);
   assign is_put     = (item.op == OP_PUT);

   // Ranks of valid slots are always a permutation of 0..count-1, so the
   // least recent slot is the one ranked count-1.
   assign oldest_age = SLOT_W'(count_ff - CNT_W'(1));

   always_comb begin
      hit_age   = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match.hit_oh[i]) begin
            hit_age   = hit_age | age_ff[i];
            hit_value = hit_value | value_ff[i];
         end
      end
   end

   assign put_hit_evict  = is_put && match.hit && (count_wide > cap_eff);
   assign put_miss_evict = is_put && !match.hit && (count_wide >= cap_eff);

   // a hit on the oldest slot promotes it, so the runner-up becomes the victim
   assign victim_age = (match.hit && (hit_age == oldest_age)) ?
                       SLOT_W'(count_ff - CNT_W'(2)) : oldest_age;

   always_comb begin
      victim_slot = '0;
      victim_key  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         victim_oh[i] = valid_ff[i] && (age_ff[i] == victim_age);
         if (victim_oh[i]) begin
            victim_slot = SLOT_W'(i);
            victim_key  = victim_key | key_ff[i];
         end
      end
   end

   assign target = put_miss_evict ? victim_slot : match.free_slot;

   always_comb begin
      result.hit         = match.hit;
      result.read_value  = is_put ? '0 : (match.hit ? hit_value : MISS_VALUE);
      result.evicted     = put_hit_evict || put_miss_evict;
      result.evicted_key = (put_hit_evict || put_miss_evict) ? victim_key : '0;
   end

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      age_in   = age_ff;
      count_in = count_ff;
      if (step) begin
         if (match.hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (match.hit_oh[i]) begin
                  age_in[i] = '0;
               end else if (valid_ff[i] && (age_ff[i] < hit_age)) begin
                  age_in[i] = age_ff[i] + SLOT_W'(1);
               end
            end
            if (is_put) begin
               value_in[match.hit_slot] = item.write_value;
               if (put_hit_evict) begin
                  valid_in[victim_slot] = 1'b0;
                  age_in[victim_slot]   = '0;
                  count_in              = count_ff - CNT_W'(1);
               end
            end
         end else if (is_put) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i]) begin
                  age_in[i] = age_ff[i] + SLOT_W'(1);
               end
            end
            valid_in[target] = 1'b1;
            key_in[target]   = item.lookup_key;
            value_in[target] = item.write_value;
            age_in[target]   = '0;
            if (!put_miss_evict) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         age_ff   <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   // fill count tracks the valid bits
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("lkv_store: fill count out of step with valid bits");

   // a key lives in at most one slot
   a_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match.hit_oh))
      else $error("lkv_store: key present in more than one slot");

   // an eviction always finds exactly one victim, never the slot just hit
   a_victim: assert property (@(posedge clock) disable iff (reset)
      step && result.evicted |-> $onehot(victim_oh) && ((victim_oh & match.hit_oh) == '0))
      else $error("lkv_store: bad victim selection");

   // an insert without eviction always has a free slot
   a_free: assert property (@(posedge clock) disable iff (reset)
      step && is_put && !match.hit && !put_miss_evict |-> match.has_free)
      else $error("lkv_store: insert with no free slot");

endmodule

/* rtl/lru_key_value_cache.sv */
// lru_key_value_cache: top level of the fully associative LRU key/value cache.
// Depends on lkv_pkg and lkv_store (which uses lkv_match).
//
// Usage
//   Request channel (req_valid / req_stall / req_data): one word per get or
//   put. A word is taken at a rising edge with req_valid high and req_stall
//   low. Response channel (rsp_valid / rsp_stall / rsp_data): exactly one
//   response word per request, in request order.
//   Capacity register: written through csr_valid / csr_ready / csr_data;
//   the user must write it only while no request is in flight, as the block
//   itself does not enforce this. csr_ready is always high.
//   Path: a request taken is held in the input register, and its response is
//   then registered in the response register, which drives rsp_valid.
//   Throughput: one word per cycle while the response channel does not stall.
//   The key compare across all slots, the recency update and the victim
//   pick are combinational, between the input and response registers.
//   Stall: while rsp_stall holds a waiting response, one more request is
//   still taken into the input register; only then does req_stall rise.
//   Reset (synchronous, active high): all slots empty, capacity 16, both
//   registers empty. Key and value storage is not cleared.
module lru_key_value_cache
   import lkv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,

   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,

   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   logic             item_valid_ff, item_valid_in;
   req_type          item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff;
   logic [CAP_W-1:0] capacity_ff;
   logic             advance;
   logic             req_take;
   rsp_type          result;

   // the held word moves on when the response register is empty or draining
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   assign csr_ready = 1'b1;

   lkv_store u_store (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (item_ff),
      .capacity (capacity_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         capacity_ff   <= CAP_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // back-pressure only ever comes from a full input register
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid_ff && rsp_valid_ff)
      else $error("lru_key_value_cache: stall without a held word");

   // every word leaving the input register lands in the response register
   a_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("lru_key_value_cache: response word lost");

   // a held response is not overwritten while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !advance)
      else $error("lru_key_value_cache: response overwritten under stall");

endmodule
